FILE: sv/lag_pkg.sv
package lag_pkg;

	// item opcodes
	localparam logic [1:0] OP_TOGGLE = 2'd0;
	localparam logic [1:0] OP_STEP   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// life rule: birth on three neighbors, survival on two or three
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_RESP
	} state_t;

	// window control shared by every column cell
	typedef struct packed {
		logic clear;
		logic load;
	} cell_ctrl_t;

endpackage

FILE: sv/life_automaton_grid.sv
// Conway life grid (birth on 3, survive on 2 or 3) of GRID_WIDTH x GRID_HEIGHT one-bit
// cells held in a RAM of one row per word, plus a 32-bit generation counter. Items come
// in on a valid/ready channel (opcode, col, row) and each gives exactly one result
// (cell_alive, generation, accepted) on a valid/ready output held in an output register,
// so a new item can be taken while the previous result still waits. Opcode toggle flips
// one cell while run_enable is 0, opcode step computes one generation while run_enable
// is 1, opcode read just returns the cell; a blocked or unused opcode changes nothing
// and reports accepted 0, and an address outside the grid reads as a dead cell.
// cell_alive always reports the addressed cell as it stands after the item.
// A step sweeps the grid one row per cycle through a three-row window kept in a row of
// GRID_WIDTH column cells; each cell hands its column sum to its two neighbors and
// the new row is written back in place two rows behind the read pointer. A toggle,
// read or blocked item passes through the RAM read, the registered read data and the
// response, which holds while the result register is full; a step sweeps every row,
// the single RAM read port delivering one row per cycle, then reads and responds.
// Items are taken one at a time. After reset a clearing pass writes every row dead,
// during which in_ready stays low; run_enable is written through cfg_we/cfg_wdata at
// any time and should change only while the block is idle.
module life_automaton_grid
	import lag_pkg::*;
#(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [5:0]  col,
	input  logic [5:0]  row,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cell_alive,
	output logic [31:0] generation,
	output logic        accepted
);

	localparam int RA   = $clog2(GRID_HEIGHT);
	localparam int CW   = $clog2(GRID_WIDTH);
	localparam int CNTW = $clog2(GRID_HEIGHT + 2);

	// control state
	state_t            state_q, state_d;
	logic [CNTW-1:0]   cnt_q;
	logic              run_enable_q;
	logic [31:0]       gen_q;
	logic              out_valid_q;

	// item held while it is worked on
	logic [1:0]        op_q;
	logic [5:0]        col_q;
	logic [5:0]        row_q;
	logic              acc_q;
	logic              inside_q;

	// result register
	logic              cell_alive_q;
	logic [31:0]       generation_q;
	logic              accepted_q;

	// ram port signals
	logic              wr_en;
	logic [RA-1:0]     wr_addr;
	logic [GRID_WIDTH-1:0] wr_data;
	logic              rd_en;
	logic [RA-1:0]     rd_addr;
	logic [GRID_WIDTH-1:0] rd_data;

	// window and column cells
	cell_ctrl_t        cell_ctrl;
	logic [GRID_WIDTH-1:0] below_row;
	logic [GRID_WIDTH-1:0] next_row;
	logic [1:0]        col_sum [GRID_WIDTH];

	logic              in_accept;
	logic              finish;
	logic              inside_in;
	logic              acc_in;
	logic [31:0]       row_w;
	logic [31:0]       col_w;
	logic [CW-1:0]     col_idx;
	logic              do_toggle;
	logic [GRID_WIDTH-1:0] toggle_mask;
	logic [CNTW-1:0]   wr_cnt;

	assign in_accept = in_valid && in_ready;

	// item address checks, widened so any grid size compares correctly
	assign inside_in = (32'(col) < 32'(GRID_WIDTH)) && (32'(row) < 32'(GRID_HEIGHT));
	assign acc_in = ((opcode == OP_TOGGLE) && !run_enable_q && inside_in)
		|| ((opcode == OP_STEP) && run_enable_q)
		|| (opcode == OP_READ);

	assign row_w       = 32'(row_q);
	assign col_w       = 32'(col_q);
	assign col_idx     = col_w[CW-1:0];
	assign do_toggle   = acc_q && (op_q == OP_TOGGLE);
	assign toggle_mask = GRID_WIDTH'(1) << col_idx;
	assign wr_cnt      = cnt_q - CNTW'(2);

	// next state, ram controls and window control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		finish    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cnt_q[RA-1:0];
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = row_w[RA-1:0];
		cell_ctrl = '0;
		below_row = '0;
		case (state_q)
			ST_CLEAR: begin
				// wipe one row per cycle after reset
				wr_en = 1'b1;
				if (cnt_q == CNTW'(GRID_HEIGHT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_accept) begin
					if ((opcode == OP_STEP) && run_enable_q) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SWEEP: begin
				// read pointer leads, rows after the last one read as dead
				if (cnt_q < CNTW'(GRID_HEIGHT)) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q[RA-1:0];
				end
				if ((cnt_q != '0) && (cnt_q <= CNTW'(GRID_HEIGHT))) begin
					below_row = rd_data;
				end
				cell_ctrl.clear = (cnt_q == '0);
				cell_ctrl.load  = (cnt_q != '0);
				// new row goes back two rows behind the read pointer
				if (cnt_q >= CNTW'(2)) begin
					wr_en   = 1'b1;
					wr_addr = wr_cnt[RA-1:0];
					wr_data = next_row;
				end
				if (cnt_q == CNTW'(GRID_HEIGHT + 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					wr_en   = do_toggle;
					wr_addr = row_w[RA-1:0];
					wr_data = rd_data ^ toggle_mask;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			run_enable_q <= 1'b0;
			gen_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				run_enable_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
				cnt_q <= (state_d == state_q) ? cnt_q + CNTW'(1) : '0;
			end
			if (state_q == ST_SWEEP && state_d == ST_READ) begin
				gen_q <= gen_q + 32'd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q     <= opcode;
			col_q    <= col;
			row_q    <= row;
			acc_q    <= acc_in;
			inside_q <= inside_in;
		end
		if (finish) begin
			cell_alive_q <= inside_q && (rd_data[col_idx] ^ do_toggle);
			generation_q <= gen_q;
			accepted_q   <= acc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_alive = cell_alive_q;
	assign generation = generation_q;
	assign accepted   = accepted_q;

	lag_ram #(
		.WIDTH(GRID_WIDTH),
		.DEPTH(GRID_HEIGHT)
	) u_grid_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one cell per column, edges see dead neighbors
	for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
		logic [1:0] left_sum;
		logic [1:0] right_sum;
		if (c == 0) begin : g_left_edge
			assign left_sum = 2'd0;
		end else begin : g_left
			assign left_sum = col_sum[c-1];
		end
		if (c == GRID_WIDTH - 1) begin : g_right_edge
			assign right_sum = 2'd0;
		end else begin : g_right
			assign right_sum = col_sum[c+1];
		end
		lag_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.below      (below_row[c]),
			.left_sum   (left_sum),
			.right_sum  (right_sum),
			.col_sum    (col_sum[c]),
			.next_alive (next_row[c])
		);
	end

	// generation count moves only as a sweep ends
	a_gen_only_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != ST_SWEEP) |-> $stable(gen_q))
		else $error("generation count changed outside a sweep");

	// in-place sweep never writes the row it is reading
	a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("sweep write collides with read row");

	// a result only appears out of the response state
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_RESP))
		else $error("result raised outside the response state");

endmodule

FILE: sv/lag_ram.sv
module lag_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/lag_cell.sv
module lag_cell
	import lag_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       below,
	input  logic [1:0] left_sum,
	input  logic [1:0] right_sum,
	output logic [1:0] col_sum,
	output logic       next_alive
);

	// rows above and at the cell being computed, for this column
	logic top_q;
	logic mid_q;
	logic [3:0] nbr_count;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			top_q <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctrl.load) begin
			top_q <= mid_q;
			mid_q <= below;
		end
	end

	assign col_sum = {1'b0, top_q} + {1'b0, mid_q} + {1'b0, below};

	// own column minus the cell itself plus both neighbor columns
	assign nbr_count = {2'b00, left_sum} + {2'b00, right_sum}
		+ {3'b000, top_q} + {3'b000, below};

	assign next_alive = (nbr_count == BIRTH_COUNT)
		|| ((nbr_count == SURVIVE_COUNT) && mid_q);

endmodule
